/* hw/rtl/vector2d_arith_unit_top_defines.svh */
// Assertion macros for the vector unit.
`ifndef VECTOR2D_ARITH_UNIT_TOP_DEFINES_SVH
`define VECTOR2D_ARITH_UNIT_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define V2D_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("vector unit check failed");
`define V2D_NEVER(lbl, expr) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	!(expr)) else $error("vector unit forbidden condition");
`else
`define V2D_ASSERT(lbl, prop)
`define V2D_NEVER(lbl, expr)
`endif
`endif

/* hw/rtl/v2d_pkg.sv */
// Types and constants of the vector unit.
package v2d_pkg;
	localparam int V2D_FRAC_BITS = 16;
	localparam int V2D_THR_W = 17;
	localparam logic [V2D_THR_W-1:0] V2D_DIV_THR_RST = 17'd1;
	localparam logic [V2D_THR_W-1:0] V2D_NORM_THR_RST = 17'd66;
	localparam int V2D_SQ_STEPS = 33;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_SCALE = 3'd2,
		OP_DIV = 3'd3,
		OP_DIST = 3'd4,
		OP_NORM = 3'd5
	} op_t;

	typedef enum logic {
		REG_DIV_THR = 1'b0,
		REG_NORM_THR = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] scal;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic sat;
		logic guard;
		logic [32:0] mag;
	} side_t;

	typedef struct packed {
		logic [32:0] root;
		logic [35:0] rem;
		logic [65:0] rad;
	} sqrt_t;
endpackage

/* hw/rtl/vector2d_arith_unit_top.sv */
// Top level of the pipelined two-dimensional vector unit.
// Usage:
//   Drive op, a_x, a_y, b_x, b_y and scalar with start high; an item is taken at
//   every clock edge where start is high and busy is low. busy stays low, so one
//   item can enter in every cycle and items never wait.
//   Each result appears for one cycle with res_valid high, in input order.
//   The pipeline has three front stages (difference, squares, sum), 33 square
//   root stages, one divisor setup stage, 32 + FRAC_BITS restoring divider
//   stages and the output register.
//   Every op runs the full pipeline, so throughput is one item per cycle.
//   The receiver cannot stall; results are not held.
//   Thresholds are written over the APB port at byte addresses 0 and 4; the user
//   must write them only while the pipeline is empty, which the block does not enforce.
//   Reset clears all valid bits and loads the thresholds with 1 and 66.
module vector2d_arith_unit_top
	import v2d_pkg::*;
#(
	parameter int FRAC_BITS = V2D_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] scalar,
	output logic               res_valid,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic [31:0]        length,
	output logic               guarded,
	output logic               saturated,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	`include "vector2d_arith_unit_top_defines.svh"

	localparam int NW = 32 + FRAC_BITS;
	localparam int LAT = 3 + V2D_SQ_STEPS + 1 + NW + 1;
	localparam logic signed [63:0] MAX64 = 64'sd2147483647;
	localparam logic signed [63:0] MIN64 = -64'sd2147483648;

	logic [V2D_THR_W-1:0] div_thr_q, norm_thr_q;

	assign pready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_thr_q <= V2D_DIV_THR_RST;
			norm_thr_q <= V2D_NORM_THR_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_DIV_THR: div_thr_q <= pwdata[V2D_THR_W-1:0];
				REG_NORM_THR: norm_thr_q <= pwdata[V2D_THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_DIV_THR: prdata = {{(32-V2D_THR_W){1'b0}}, div_thr_q};
			REG_NORM_THR: prdata = {{(32-V2D_THR_W){1'b0}}, norm_thr_q};
			default: prdata = '0;
		endcase
	end

	// stage 1: differences, add/sub, scale products
	logic v_s1;
	side_t side_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [63:0] px_s1, py_s1;
	logic signed [32:0] sum_x, sum_y;
	logic signed [31:0] as_x, as_y;
	logic as_sat;

	always_comb begin
		if (op == OP_SUB) begin
			sum_x = {a_x[31], a_x} - {b_x[31], b_x};
			sum_y = {a_y[31], a_y} - {b_y[31], b_y};
		end else begin
			sum_x = {a_x[31], a_x} + {b_x[31], b_x};
			sum_y = {a_y[31], a_y} + {b_y[31], b_y};
		end
		as_sat = 1'b0;
		as_x = sum_x[31:0];
		as_y = sum_y[31:0];
		if (sum_x[32] != sum_x[31]) begin
			as_sat = 1'b1;
			as_x = sum_x[32] ? 32'sh80000000 : 32'sh7fffffff;
		end
		if (sum_y[32] != sum_y[31]) begin
			as_sat = 1'b1;
			as_y = sum_y[32] ? 32'sh80000000 : 32'sh7fffffff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		side_s1.op <= op;
		side_s1.ax <= a_x;
		side_s1.ay <= a_y;
		side_s1.scal <= scalar;
		side_s1.rx <= as_x;
		side_s1.ry <= as_y;
		side_s1.sat <= as_sat;
		side_s1.guard <= 1'b0;
		side_s1.mag <= '0;
		if (op == OP_NORM) begin
			dx_s1 <= {a_x[31], a_x};
			dy_s1 <= {a_y[31], a_y};
		end else begin
			dx_s1 <= {a_x[31], a_x} - {b_x[31], b_x};
			dy_s1 <= {a_y[31], a_y} - {b_y[31], b_y};
		end
		px_s1 <= 64'(a_x) * 64'(scalar);
		py_s1 <= 64'(a_y) * 64'(scalar);
	end

	// stage 2: squares, scale shift and clip
	logic v_s2;
	side_t side_s2;
	side_t side_n2;
	logic [65:0] sqx_s2, sqy_s2;
	logic [32:0] ux, uy;
	logic signed [63:0] shx, shy;

	assign ux = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
	assign uy = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
	assign shx = px_s1 >>> FRAC_BITS;
	assign shy = py_s1 >>> FRAC_BITS;

	always_comb begin
		side_n2 = side_s1;
		if (side_s1.op == OP_SCALE) begin
			side_n2.sat = (shx > MAX64) || (shx < MIN64) || (shy > MAX64) || (shy < MIN64);
			side_n2.rx = (shx > MAX64) ? 32'sh7fffffff :
				(shx < MIN64) ? 32'sh80000000 : shx[31:0];
			side_n2.ry = (shy > MAX64) ? 32'sh7fffffff :
				(shy < MIN64) ? 32'sh80000000 : shy[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= 66'(ux) * 66'(ux);
		sqy_s2 <= 66'(uy) * 66'(uy);
		side_s2 <= side_n2;
	end

	// stage 3: sum of squares
	logic v_s3;
	side_t side_s3;
	logic [65:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		rad_s3 <= sqx_s2 + sqy_s2;
		side_s3 <= side_s2;
	end

	// square root, two radicand bits per stage
	logic v_s4 [V2D_SQ_STEPS];
	side_t side_s4 [V2D_SQ_STEPS];
	sqrt_t sqrt_s4 [V2D_SQ_STEPS];

	for (genvar k = 0; k < V2D_SQ_STEPS; k++) begin : g_sqrt
		localparam int HI = 2 * (V2D_SQ_STEPS - 1 - k) + 1;
		sqrt_t prev;
		logic prev_v;
		side_t prev_side;
		logic [35:0] rem_new, trial;

		if (k == 0) begin : g_first
			assign prev = '{root: '0, rem: '0, rad: rad_s3};
			assign prev_v = v_s3;
			assign prev_side = side_s3;
		end else begin : g_next
			assign prev = sqrt_s4[k-1];
			assign prev_v = v_s4[k-1];
			assign prev_side = side_s4[k-1];
		end

		assign rem_new = {prev.rem[33:0], prev.rad[HI -: 2]};
		assign trial = {1'b0, prev.root, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s4[k] <= 1'b0;
			else v_s4[k] <= prev_v;
		end

		always_ff @(posedge clk) begin
			side_s4[k] <= prev_side;
			sqrt_s4[k].rad <= prev.rad;
			if (rem_new >= trial) begin
				sqrt_s4[k].rem <= rem_new - trial;
				sqrt_s4[k].root <= {prev.root[31:0], 1'b1};
			end else begin
				sqrt_s4[k].rem <= rem_new;
				sqrt_s4[k].root <= {prev.root[31:0], 1'b0};
			end
		end
	end

	// stage 5: divisor, dividends and threshold guards
	logic v_s5;
	side_t side_s5;
	logic [32:0] d_s5;
	logic [NW-1:0] nx_s5, ny_s5;
	logic nx_neg_s5, ny_neg_s5;
	side_t side_l;
	side_t side_n5;
	logic [32:0] mag_l;
	logic [31:0] abs_x, abs_y;
	logic guard_c;

	assign side_l = side_s4[V2D_SQ_STEPS-1];
	assign mag_l = sqrt_s4[V2D_SQ_STEPS-1].root;
	assign abs_x = side_l.ax[31] ? 32'(-side_l.ax) : 32'(side_l.ax);
	assign abs_y = side_l.ay[31] ? 32'(-side_l.ay) : 32'(side_l.ay);

	always_comb begin
		guard_c = 1'b0;
		if (side_l.op == OP_DIV)
			guard_c = (side_l.scal <= 32'sd0) ||
				(side_l.scal < $signed({{(32-V2D_THR_W){1'b0}}, div_thr_q}));
		else if (side_l.op == OP_NORM)
			guard_c = (mag_l == '0) || (mag_l < {{(33-V2D_THR_W){1'b0}}, norm_thr_q});
	end

	always_comb begin
		side_n5 = side_l;
		side_n5.mag = mag_l;
		side_n5.guard = guard_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4[V2D_SQ_STEPS-1];
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_n5;
		d_s5 <= (side_l.op == OP_DIV) ? {1'b0, side_l.scal} : mag_l;
		nx_s5 <= {abs_x, {FRAC_BITS{1'b0}}};
		ny_s5 <= {abs_y, {FRAC_BITS{1'b0}}};
		nx_neg_s5 <= side_l.ax[31];
		ny_neg_s5 <= side_l.ay[31];
	end

	// restoring divider, one quotient bit per stage, two lanes
	logic v_s6 [NW];
	side_t side_s6 [NW];
	logic [32:0] d_s6 [NW];
	logic [NW-1:0] nx_s6 [NW], ny_s6 [NW], qx_s6 [NW], qy_s6 [NW];
	logic [32:0] rx_s6 [NW], ry_s6 [NW];
	logic xneg_s6 [NW], yneg_s6 [NW];

	for (genvar j = 0; j < NW; j++) begin : g_div
		logic pv, pxn, pyn;
		side_t ps;
		logic [32:0] pd, prx, pry;
		logic [NW-1:0] pnx, pny, pqx, pqy;
		logic [33:0] tx, ty;

		if (j == 0) begin : g_first
			assign pv = v_s5;
			assign ps = side_s5;
			assign pd = d_s5;
			assign pnx = nx_s5;
			assign pny = ny_s5;
			assign pqx = '0;
			assign pqy = '0;
			assign prx = '0;
			assign pry = '0;
			assign pxn = nx_neg_s5;
			assign pyn = ny_neg_s5;
		end else begin : g_next
			assign pv = v_s6[j-1];
			assign ps = side_s6[j-1];
			assign pd = d_s6[j-1];
			assign pnx = nx_s6[j-1];
			assign pny = ny_s6[j-1];
			assign pqx = qx_s6[j-1];
			assign pqy = qy_s6[j-1];
			assign prx = rx_s6[j-1];
			assign pry = ry_s6[j-1];
			assign pxn = xneg_s6[j-1];
			assign pyn = yneg_s6[j-1];
		end

		assign tx = {prx, pnx[NW-1-j]};
		assign ty = {pry, pny[NW-1-j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s6[j] <= 1'b0;
			else v_s6[j] <= pv;
		end

		always_ff @(posedge clk) begin
			side_s6[j] <= ps;
			d_s6[j] <= pd;
			nx_s6[j] <= pnx;
			ny_s6[j] <= pny;
			xneg_s6[j] <= pxn;
			yneg_s6[j] <= pyn;
			if (tx >= {1'b0, pd}) begin
				rx_s6[j] <= 33'(tx - {1'b0, pd});
				qx_s6[j] <= {pqx[NW-2:0], 1'b1};
			end else begin
				rx_s6[j] <= tx[32:0];
				qx_s6[j] <= {pqx[NW-2:0], 1'b0};
			end
			if (ty >= {1'b0, pd}) begin
				ry_s6[j] <= 33'(ty - {1'b0, pd});
				qy_s6[j] <= {pqy[NW-2:0], 1'b1};
			end else begin
				ry_s6[j] <= ty[32:0];
				qy_s6[j] <= {pqy[NW-2:0], 1'b0};
			end
		end
	end

	// output stage
	side_t so;
	logic [NW-1:0] qxo, qyo;
	logic signed [31:0] qx_val, qy_val;
	logic qx_sat, qy_sat;
	logic signed [31:0] rx_n, ry_n;
	logic [31:0] len_n;
	logic guard_n, sat_n;

	assign so = side_s6[NW-1];
	assign qxo = qx_s6[NW-1];
	assign qyo = qy_s6[NW-1];

	always_comb begin
		qx_sat = 1'b0;
		qy_sat = 1'b0;
		if (!xneg_s6[NW-1]) begin
			qx_sat = |qxo[NW-1:31];
			qx_val = qx_sat ? 32'sh7fffffff : $signed(qxo[31:0]);
		end else begin
			qx_sat = (|qxo[NW-1:32]) || (qxo[31] && (|qxo[30:0]));
			qx_val = qx_sat ? 32'sh80000000 : $signed(32'(-qxo[31:0]));
		end
		if (!yneg_s6[NW-1]) begin
			qy_sat = |qyo[NW-1:31];
			qy_val = qy_sat ? 32'sh7fffffff : $signed(qyo[31:0]);
		end else begin
			qy_sat = (|qyo[NW-1:32]) || (qyo[31] && (|qyo[30:0]));
			qy_val = qy_sat ? 32'sh80000000 : $signed(32'(-qyo[31:0]));
		end
	end

	always_comb begin
		rx_n = '0;
		ry_n = '0;
		len_n = '0;
		guard_n = 1'b0;
		sat_n = 1'b0;
		case (so.op)
			OP_ADD, OP_SUB, OP_SCALE: begin
				rx_n = so.rx;
				ry_n = so.ry;
				sat_n = so.sat;
			end
			OP_DIV, OP_NORM: begin
				if (so.guard) begin
					guard_n = 1'b1;
				end else begin
					rx_n = qx_val;
					ry_n = qy_val;
					sat_n = qx_sat || qy_sat;
				end
			end
			OP_DIST: begin
				len_n = so.mag[32] ? 32'hffffffff : so.mag[31:0];
				sat_n = so.mag[32];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else res_valid <= v_s6[NW-1];
	end

	always_ff @(posedge clk) begin
		res_x <= rx_n;
		res_y <= ry_n;
		length <= len_n;
		guarded <= guard_n;
		saturated <= sat_n;
	end

	`V2D_ASSERT(a_latency, start && !busy |-> ##LAT res_valid)
	`V2D_ASSERT(a_guard_zero, res_valid && guarded |-> res_x == 0 && res_y == 0 && length == 0)
	`V2D_ASSERT(a_len_only, res_valid && length != 0 |-> res_x == 0 && res_y == 0)
	`V2D_NEVER(a_guard_sat, res_valid && guarded && saturated)
endmodule
